[sv/shape_overlap_tester_assert.svh]
// Assertion macros used by the shape overlap tester RTL.
`ifndef SHAPE_OVERLAP_TESTER_ASSERT_SVH
`define SHAPE_OVERLAP_TESTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shape_overlap_tester assertion failed");

// Next-cycle implication, checked outside reset.
`define SOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shape_overlap_tester assertion failed");

`else

`define SOT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/sot_pkg.sv]
// Types and constants of the shape overlap tester.
package sot_pkg;

    // Coordinate width and the widths derived from it.
    localparam int COORD_BITS = 32;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int DIFF_BITS  = SUM_BITS + 1;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int RSQ_BITS   = 2 * COORD_BITS;
    localparam int OP_BITS    = 3;

    // Operation codes.
    typedef enum logic [OP_BITS-1:0] {
        OP_RECT_RECT     = 3'd0,
        OP_CIRCLE_CIRCLE = 3'd1,
        OP_RECT_CIRCLE   = 3'd2,
        OP_POINT_RECT    = 3'd3,
        OP_POINT_CIRCLE  = 3'd4
    } t_op;

    // One input item.
    typedef struct packed {
        logic [OP_BITS-1:0]          operation;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic [SIZE_BITS-1:0]         a_width;
        logic [SIZE_BITS-1:0]         a_height;
        logic [SIZE_BITS-1:0]         a_radius;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic [SIZE_BITS-1:0]         b_width;
        logic [SIZE_BITS-1:0]         b_height;
        logic [SIZE_BITS-1:0]         b_radius;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic overlap;
        logic bad_operation;
    } t_out_item;

    // Hand-over from the edge stages to the distance stages.
    typedef struct packed {
        logic                       need_dist;
        logic                       rect_hit;
        logic                       bad;
        logic signed [SUM_BITS-1:0] p_x;
        logic signed [SUM_BITS-1:0] q_x;
        logic signed [SUM_BITS-1:0] p_y;
        logic signed [SUM_BITS-1:0] q_y;
        logic [COORD_BITS-1:0]      radius;
    } t_front;

endpackage

[sv/sot_if.sv]
// Valid/ready channel interfaces for input items and results.
interface sot_item_if;
    import sot_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sot_result_if;
    import sot_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/sot_edge.sv]
// Edge stages: rectangle edges, edge comparisons, clamping and operand choice.
module sot_edge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sot_pkg::t_in_item i_item,
    output logic            o_valid,
    output sot_pkg::t_front o_front
);
    import sot_pkg::*;

    // Stage one registers: edges at one bit of headroom.
    logic                       r1_valid;
    logic [OP_BITS-1:0]         r1_op;
    logic signed [SUM_BITS-1:0] r1_a_l, r1_a_r, r1_a_t, r1_a_b;
    logic signed [SUM_BITS-1:0] r1_b_l, r1_b_r, r1_b_t, r1_b_b;
    logic [COORD_BITS-1:0]      r1_rsum;
    logic [SIZE_BITS-1:0]       r1_ar, r1_br;

    logic signed [SUM_BITS-1:0] n1_a_l, n1_a_t, n1_b_l, n1_b_t;
    logic signed [SUM_BITS-1:0] n1_a_w, n1_a_h, n1_b_w, n1_b_h;

    // Stage two registers.
    logic   r2_valid;
    t_front r2_front;
    t_front n2_front;

    logic rr_hit, pr_hit;
    logic signed [SUM_BITS-1:0] cx, cy;

    // Sign-extend the corners and zero-extend the sizes.
    assign n1_a_l = {i_item.a_x[COORD_BITS-1], i_item.a_x};
    assign n1_a_t = {i_item.a_y[COORD_BITS-1], i_item.a_y};
    assign n1_b_l = {i_item.b_x[COORD_BITS-1], i_item.b_x};
    assign n1_b_t = {i_item.b_y[COORD_BITS-1], i_item.b_y};
    assign n1_a_w = {2'b00, i_item.a_width};
    assign n1_a_h = {2'b00, i_item.a_height};
    assign n1_b_w = {2'b00, i_item.b_width};
    assign n1_b_h = {2'b00, i_item.b_height};

    // Stage one: right and bottom edges, and the radius sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_op   <= i_item.operation;
            r1_a_l  <= n1_a_l;
            r1_a_t  <= n1_a_t;
            r1_b_l  <= n1_b_l;
            r1_b_t  <= n1_b_t;
            r1_a_r  <= n1_a_l + n1_a_w;
            r1_a_b  <= n1_a_t + n1_a_h;
            r1_b_r  <= n1_b_l + n1_b_w;
            r1_b_b  <= n1_b_t + n1_b_h;
            r1_rsum <= {1'b0, i_item.a_radius} + {1'b0, i_item.b_radius};
            r1_ar   <= i_item.a_radius;
            r1_br   <= i_item.b_radius;
        end
    end

    // Strict rectangle test, and the half-open point test.
    assign rr_hit = (r1_a_l < r1_b_r) && (r1_a_r > r1_b_l) &&
                    (r1_a_t < r1_b_b) && (r1_a_b > r1_b_t);
    assign pr_hit = (r1_b_l >= r1_a_l) && (r1_b_t >= r1_a_t) &&
                    (r1_b_l < r1_a_r) && (r1_b_t < r1_a_b);

    // Clamp the circle centre to the rectangle.
    always_comb begin
        if (r1_b_l < r1_a_l) begin
            cx = r1_a_l;
        end else if (r1_b_l > r1_a_r) begin
            cx = r1_a_r;
        end else begin
            cx = r1_b_l;
        end
        if (r1_b_t < r1_a_t) begin
            cy = r1_a_t;
        end else if (r1_b_t > r1_a_b) begin
            cy = r1_a_b;
        end else begin
            cy = r1_b_t;
        end
    end

    // Pick the points whose distance is measured, and the radius.
    always_comb begin
        n2_front           = '0;
        n2_front.p_x       = r1_a_l;
        n2_front.q_x       = r1_b_l;
        n2_front.p_y       = r1_a_t;
        n2_front.q_y       = r1_b_t;
        case (t_op'(r1_op))
            OP_RECT_RECT: begin
                n2_front.rect_hit = rr_hit;
            end
            OP_CIRCLE_CIRCLE: begin
                n2_front.need_dist = 1'b1;
                n2_front.radius    = r1_rsum;
            end
            OP_RECT_CIRCLE: begin
                n2_front.need_dist = 1'b1;
                n2_front.p_x       = cx;
                n2_front.p_y       = cy;
                n2_front.radius    = COORD_BITS'(r1_br);
            end
            OP_POINT_RECT: begin
                n2_front.rect_hit = pr_hit;
            end
            OP_POINT_CIRCLE: begin
                n2_front.need_dist = 1'b1;
                n2_front.p_x       = r1_b_l;
                n2_front.q_x       = r1_a_l;
                n2_front.p_y       = r1_b_t;
                n2_front.q_y       = r1_a_t;
                n2_front.radius    = COORD_BITS'(r1_ar);
            end
            default: begin
                n2_front.bad = 1'b1;
            end
        endcase
    end

    // Stage two register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_front <= n2_front;
        end
    end

    assign o_valid = r2_valid;
    assign o_front = r2_front;
endmodule

[sv/sot_dist.sv]
// Distance stages: differences, squares and the final compare.
module sot_dist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sot_pkg::t_front    i_front,
    output logic               o_valid,
    output sot_pkg::t_out_item o_result
);
    import sot_pkg::*;

    logic signed [DIFF_BITS-1:0] d_x, d_y;
    logic [DIFF_BITS-1:0]        abs_x, abs_y;

    // Stage three: magnitudes of the differences.
    logic                  r3_valid;
    logic                  r3_need, r3_hit, r3_bad;
    logic [MAG_BITS-1:0]   r3_mag_x, r3_mag_y;
    logic [COORD_BITS-1:0] r3_radius;

    // Stage four: squares.
    logic                  r4_valid;
    logic                  r4_need, r4_hit, r4_bad;
    logic [SQ_BITS-1:0]    r4_sq_x, r4_sq_y;
    logic [RSQ_BITS-1:0]   r4_rsq;

    // Stage five: result.
    logic                  r5_valid;
    t_out_item             r5_result;
    logic [DIST_BITS-1:0]  dist_sq;
    logic                  dist_hit;

    assign d_x   = {i_front.p_x[SUM_BITS-1], i_front.p_x} -
                   {i_front.q_x[SUM_BITS-1], i_front.q_x};
    assign d_y   = {i_front.p_y[SUM_BITS-1], i_front.p_y} -
                   {i_front.q_y[SUM_BITS-1], i_front.q_y};
    assign abs_x = d_x[DIFF_BITS-1] ? -d_x : d_x;
    assign abs_y = d_y[DIFF_BITS-1] ? -d_y : d_y;

    assign dist_sq  = {1'b0, r4_sq_x} + {1'b0, r4_sq_y};
    assign dist_hit = dist_sq < DIST_BITS'(r4_rsq);

    // Pipeline registers, all moving together under the stage enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
        if (i_en) begin
            r3_need   <= i_front.need_dist;
            r3_hit    <= i_front.rect_hit;
            r3_bad    <= i_front.bad;
            r3_mag_x  <= abs_x[MAG_BITS-1:0];
            r3_mag_y  <= abs_y[MAG_BITS-1:0];
            r3_radius <= i_front.radius;

            r4_need   <= r3_need;
            r4_hit    <= r3_hit;
            r4_bad    <= r3_bad;
            r4_sq_x   <= r3_mag_x * r3_mag_x;
            r4_sq_y   <= r3_mag_y * r3_mag_y;
            r4_rsq    <= r3_radius * r3_radius;

            r5_result.overlap       <= r4_need ? dist_hit : r4_hit;
            r5_result.bad_operation <= r4_bad;
        end
    end

    assign o_valid  = r5_valid;
    assign o_result = r5_result;
endmodule

[sv/sot_skid.sv]
// Two-entry output buffer that registers the ready path back into the pipeline.
module sot_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sot_pkg::t_out_item i_data,
    output logic               o_ready,
    sot_result_if.source       o_out
);
    import sot_pkg::*;

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;

    assign o_ready     = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // The output register refills from the skid entry first, else from the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (o_out.ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_out_data  <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end
endmodule

[sv/shape_overlap_tester.sv]
// Top level of the 2D shape overlap tester.
//
//  Channel    Dir  Modport  Payload
//  i_item     in   sink     operation, shape a, shape b (t_in_item)
//  o_result   out  source   overlap, bad_operation (t_out_item)
//
// One item per cycle is accepted while the output buffer has room; a result passes through stage
// registers one to five, then the output register, before it is offered.
// Synchronous active-low reset empties the pipeline and the output buffer.
// A stall at the output freezes all five stages at once when the second buffer entry is full; the
// two-entry output buffer keeps the input ready from depending on the output ready combinationally.
module shape_overlap_tester (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sot_item_if.sink      i_item,
    sot_result_if.source  o_result
);
    import sot_pkg::*;

    `include "shape_overlap_tester_assert.svh"

    logic      w_pipe_en;
    logic      w_front_valid;
    t_front    w_front;
    logic      w_dist_valid;
    t_out_item w_dist_result;

    assign i_item.ready = w_pipe_en;

    // Edge comparisons, clamping and operand choice.
    sot_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_pipe_en),
        .i_valid (i_item.valid),
        .i_item  (i_item.data),
        .o_valid (w_front_valid),
        .o_front (w_front)
    );

    // Squared distances against the squared radius.
    sot_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_pipe_en),
        .i_valid  (w_front_valid),
        .i_front  (w_front),
        .o_valid  (w_dist_valid),
        .o_result (w_dist_result)
    );

    // Output buffer.
    sot_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dist_valid),
        .i_data  (w_dist_result),
        .o_ready (w_pipe_en),
        .o_out   (o_result)
    );

    // An unknown operation never reports an overlap.
    `SOT_ASSERT_NOW(a_bad_no_overlap, i_clk, i_rst_n, o_result.valid && o_result.data.bad_operation, !o_result.data.overlap)

    // A stalled item in the middle of the pipeline is held, not dropped.
    `SOT_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, w_front_valid && !w_pipe_en, w_front_valid && $stable(w_front))

    // The buffer only fills its second entry behind a waiting result.
    `SOT_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, !w_pipe_en, o_result.valid)
endmodule

[bench/shape_overlap_checker.sv]
// Watches both channels of the shape overlap tester, predicts each verdict and compares.
module shape_overlap_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sot_item_if   i_item,
    sot_result_if i_result,
    output int    o_mismatches,
    output int    o_awaited
);
    import sot_pkg::*;

    // Verdicts predicted for accepted items, oldest first.
    t_out_item pending_verdicts[$];
    int        mismatch_count = 0;
    int        awaited_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_awaited    = awaited_count;

    // Squared distance strictly below the squared radius, at full width.
    function automatic logic dist_below(longint dx, longint dy, longint r);
        logic signed [127:0] wx;
        logic signed [127:0] wy;
        logic signed [127:0] wr;
        wx = 128'(dx);
        wy = 128'(dy);
        wr = 128'(r);
        return (wx * wx + wy * wy) < (wr * wr);
    endfunction

    function automatic longint clamp_into(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Expected verdict for one pair of shapes.
    function automatic t_out_item overlap_verdict(t_in_item it);
        longint    ax, ay, aw, ah, ar;
        longint    bx, by, bw, bh, br;
        longint    cx, cy;
        t_out_item res;
        ax  = longint'(it.a_x);
        ay  = longint'(it.a_y);
        aw  = longint'(it.a_width);
        ah  = longint'(it.a_height);
        ar  = longint'(it.a_radius);
        bx  = longint'(it.b_x);
        by  = longint'(it.b_y);
        bw  = longint'(it.b_width);
        bh  = longint'(it.b_height);
        br  = longint'(it.b_radius);
        res = '0;
        case (it.operation)
            OP_RECT_RECT: begin
                res.overlap = (ax < bx + bw) && (ax + aw > bx) &&
                              (ay < by + bh) && (ay + ah > by);
            end
            OP_CIRCLE_CIRCLE: begin
                res.overlap = dist_below(ax - bx, ay - by, ar + br);
            end
            OP_RECT_CIRCLE: begin
                // Nearest point of the rectangle to the circle centre.
                cx = clamp_into(bx, ax, ax + aw);
                cy = clamp_into(by, ay, ay + ah);
                res.overlap = dist_below(cx - bx, cy - by, br);
            end
            OP_POINT_RECT: begin
                // Left and top edges belong to the rectangle, right and bottom do not.
                res.overlap = (bx >= ax) && (by >= ay) && (bx < ax + aw) && (by < ay + ah);
            end
            OP_POINT_CIRCLE: begin
                res.overlap = dist_below(bx - ax, by - ay, ar);
            end
            default: begin
                res.bad_operation = 1'b1;
            end
        endcase
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, t_out_item got, t_out_item want);
        $display("%0t: %s: got overlap=%0b bad_operation=%0b, expected %0b %0b",
                 $realtime, what, got.overlap, got.bad_operation,
                 want.overlap, want.bad_operation);
        mismatch_count++;
    endtask

    // Results are matched before new items are queued, so a stray result is never
    // paired with an item from the same edge.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (i_result.valid && i_result.ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result transfer with nothing expected", i_result.data, '0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_result.data.overlap !== want.overlap) begin
                        report_mismatch("overlap differs", i_result.data, want);
                    end
                    if (i_result.data.bad_operation !== want.bad_operation) begin
                        report_mismatch("bad_operation differs", i_result.data, want);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                pending_verdicts.push_back(overlap_verdict(i_item.data));
            end
            awaited_count = pending_verdicts.size();
        end
    end

endmodule

[bench/tb_shape_overlap_tester.sv]
// Top of the shape overlap tester bench: clock, reset, stimulus and verdict.
module tb_shape_overlap_tester;
    import sot_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int ONE            = 65536;
    localparam int C_MIN          = -2147483647 - 1;
    localparam int C_MAX          = 2147483647;
    localparam int S_MAX          = 2147483647;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   awaited;
    // Set while both sides run without idling.
    bit   calm = 1'b0;

    sot_item_if   item_ch ();
    sot_result_if result_ch ();

    shape_overlap_tester u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    shape_overlap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Result side stalls at random, except during the calm stretch.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            result_ch.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("[shape_overlap_tester] ERROR");
        $finish;
    end

    // A pair of shapes with every field random.
    function automatic t_in_item noise_shapes();
        t_in_item it;
        it.operation = OP_BITS'($urandom_range((1 << OP_BITS) - 1));
        it.a_x       = $urandom;
        it.a_y       = $urandom;
        it.a_width   = SIZE_BITS'($urandom);
        it.a_height  = SIZE_BITS'($urandom);
        it.a_radius  = SIZE_BITS'($urandom);
        it.b_x       = $urandom;
        it.b_y       = $urandom;
        it.b_width   = SIZE_BITS'($urandom);
        it.b_height  = SIZE_BITS'($urandom);
        it.b_radius  = SIZE_BITS'($urandom);
        return it;
    endfunction

    // Random signed offset within plus or minus the given span.
    function automatic int spread(int unsigned span);
        return int'($urandom_range(2 * span)) - int'(span);
    endfunction

    // Shapes clustered around one centre so that hits and misses both occur,
    // sometimes snapped onto an edge.
    function automatic t_in_item clustered_shapes();
        t_in_item    it;
        int unsigned span;
        int          centre;
        it = noise_shapes();
        if ($urandom_range(15) != 0) begin
            it.operation = OP_BITS'($urandom_range(OP_POINT_CIRCLE));
        end
        span        = 1 << $urandom_range(2, 30);
        centre      = $urandom;
        it.a_x      = centre + spread(span);
        it.a_y      = centre + spread(span);
        it.a_width  = SIZE_BITS'($urandom_range(span));
        it.a_height = SIZE_BITS'($urandom_range(span));
        it.a_radius = SIZE_BITS'($urandom_range(span));
        it.b_x      = centre + spread(span);
        it.b_y      = centre + spread(span);
        it.b_width  = SIZE_BITS'($urandom_range(span));
        it.b_height = SIZE_BITS'($urandom_range(span));
        it.b_radius = SIZE_BITS'($urandom_range(span));
        case ($urandom_range(5))
            0: it.b_x = it.a_x + it.a_width;
            1: it.b_y = it.a_y + it.a_height;
            2: it.b_x = it.a_x;
            default: ;
        endcase
        return it;
    endfunction

    // Offers one item and holds it until the transfer; outside the calm stretch it may first idle at random.
    task automatic offer_shapes(t_in_item it);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 20) begin
            item_ch.valid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Directed pair; some fields the operation does not use are left random.
    task automatic offer_case(logic [OP_BITS-1:0] op, int ax, int ay, int aw, int ah, int ar,
                              int bx, int by, int bw, int bh, int br);
        t_in_item it;
        it = noise_shapes();
        it.operation = op;
        it.a_x       = ax;
        it.a_y       = ay;
        if (op == OP_CIRCLE_CIRCLE || op == OP_POINT_CIRCLE) begin
            it.a_radius = SIZE_BITS'(ar);
        end else begin
            it.a_width  = SIZE_BITS'(aw);
            it.a_height = SIZE_BITS'(ah);
        end
        if (op != OP_POINT_RECT && op != OP_POINT_CIRCLE) begin
            it.b_width  = SIZE_BITS'(bw);
            it.b_height = SIZE_BITS'(bh);
            it.b_radius = SIZE_BITS'(br);
        end
        it.b_x = bx;
        it.b_y = by;
        offer_shapes(it);
    endtask

    // Reset, directed cases, random cases, drain and verdict.
    initial begin : stimulus
        t_in_item it;
        int       k;
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Rectangle against rectangle: overlap, shared edge, extremes, zero width.
        offer_case(OP_RECT_RECT, 0, 0, 10 * ONE, 10 * ONE, 0, 5 * ONE, 5 * ONE, 10 * ONE, 10 * ONE, 0);
        offer_case(OP_RECT_RECT, 0, 0, 10 * ONE, 10 * ONE, 0, 10 * ONE, 0, ONE, ONE, 0);
        offer_case(OP_RECT_RECT, C_MIN, C_MIN, S_MAX, S_MAX, 0, -2, -2, S_MAX, S_MAX, 0);
        offer_case(OP_RECT_RECT, C_MIN, C_MIN, S_MAX, S_MAX, 0, C_MAX, C_MAX, S_MAX, S_MAX, 0);
        offer_case(OP_RECT_RECT, ONE, ONE, 0, ONE, 0, 0, 0, 4 * ONE, 4 * ONE, 0);

        // Circle against circle: tangent, just overlapping, extremes, zero radii.
        offer_case(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 3 * ONE);
        offer_case(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 3 * ONE + 1);
        offer_case(OP_CIRCLE_CIRCLE, C_MIN, C_MIN, 0, 0, S_MAX, C_MAX, C_MAX, 0, 0, S_MAX);
        offer_case(OP_CIRCLE_CIRCLE, C_MAX, C_MIN, 0, 0, 1, C_MAX, C_MIN, 0, 0, 0);
        offer_case(OP_CIRCLE_CIRCLE, ONE, ONE, 0, 0, 0, ONE, ONE, 0, 0, 0);

        // Rectangle against circle: centre inside, tangent at a corner, zero radius, extremes.
        offer_case(OP_RECT_CIRCLE, 0, 0, 4 * ONE, 4 * ONE, 0, 2 * ONE, 2 * ONE, 0, 0, ONE);
        offer_case(OP_RECT_CIRCLE, 0, 0, 4 * ONE, 4 * ONE, 0, 7 * ONE, 8 * ONE, 0, 0, 5 * ONE);
        offer_case(OP_RECT_CIRCLE, 0, 0, 4 * ONE, 4 * ONE, 0, 2 * ONE, 2 * ONE, 0, 0, 0);
        offer_case(OP_RECT_CIRCLE, C_MIN, C_MIN, S_MAX, S_MAX, 0, C_MAX, C_MAX, 0, 0, S_MAX);

        // Point in rectangle: inclusive top-left corner, exclusive right and bottom edges.
        offer_case(OP_POINT_RECT, ONE, ONE, 2 * ONE, 2 * ONE, 0, ONE, ONE, 0, 0, 0);
        offer_case(OP_POINT_RECT, ONE, ONE, 2 * ONE, 2 * ONE, 0, 3 * ONE, ONE, 0, 0, 0);
        offer_case(OP_POINT_RECT, ONE, ONE, 2 * ONE, 2 * ONE, 0, ONE, 3 * ONE, 0, 0, 0);
        offer_case(OP_POINT_RECT, C_MIN, C_MIN, S_MAX, S_MAX, 0, -2, -2, 0, 0, 0);
        offer_case(OP_POINT_RECT, C_MIN, C_MIN, S_MAX, S_MAX, 0, -1, -1, 0, 0, 0);

        // Point in circle: on the boundary, zero radius, extremes.
        offer_case(OP_POINT_CIRCLE, 0, 0, 0, 0, 5 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0);
        offer_case(OP_POINT_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer_case(OP_POINT_CIRCLE, C_MAX, C_MAX, 0, 0, S_MAX, C_MIN, C_MIN, 0, 0, 0);
        offer_case(OP_POINT_CIRCLE, C_MIN, C_MAX, 0, 0, S_MAX, -2, C_MAX, 0, 0, 0);

        // Every unknown operation code.
        for (k = OP_POINT_CIRCLE + 1; k < (1 << OP_BITS); k++) begin
            it = noise_shapes();
            it.operation = OP_BITS'(k);
            offer_shapes(it);
        end

        // Random part: mostly clustered shapes, some pure noise, with a calm stretch.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= 400) && (k < 650);
            if ($urandom_range(9) < 3) begin
                it = noise_shapes();
            end else begin
                it = clustered_shapes();
            end
            offer_shapes(it);
        end
        calm = 1'b0;
        @(negedge i_clk);
        item_ch.valid <= 1'b0;

        // Wait for every verdict, then keep watching for anything stray.
        while (awaited != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("[shape_overlap_tester] OK");
        end else begin
            $display("[shape_overlap_tester] ERROR");
        end
        $finish;
    end

endmodule
